@@ rtl/core/btbr_pkg.sv @@
// Shared types and constants for the branch target buffer resolve unit.
`timescale 1ns / 1ps

package btbr_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned PEN_W     = 10;
  localparam int unsigned STALL_W   = 11;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SET_SHIFT = 2;
  // width of the address once the byte-in-word bits are dropped
  localparam int unsigned VAL_W     = ADDR_W - SET_SHIFT;

  localparam int unsigned IN_TDATA_W  = 200;
  localparam int unsigned OUT_TDATA_W = 208;

  localparam logic [KIND_W-1:0] KIND_COND = 3'd0;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_PEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISPRED_PEN = 2'd1;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] stamp;
  } btbr_entry_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] target;
  } btbr_scan_t;

endpackage

@@ rtl/core/btbr_set_index.sv @@
// Set index unit: (address >> 2) mod SETS, a mask or a 4-bit-per-cycle remainder loop.
`timescale 1ns / 1ps

module btbr_set_index #(
  parameter int unsigned SETS  = 512,
  parameter int unsigned SET_W = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [btbr_pkg::VAL_W-1:0] value_i,
  output logic                      done_o,
  output logic [SET_W-1:0]          set_o
);
  import btbr_pkg::*;

  if ((SETS & (SETS - 1)) == 0) begin : g_pow2
    logic             done_q;
    logic [SET_W-1:0] set_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        set_q <= SET_W'(value_i & VAL_W'(SETS - 1));
      end
    end

    assign done_o = done_q;
    assign set_o  = set_q;
  end else begin : g_iter
    localparam int unsigned DIG   = 4;
    localparam int unsigned STEPS = (VAL_W + DIG - 1) / DIG;
    localparam int unsigned SH_W  = STEPS * DIG;
    localparam int unsigned STP_W = $clog2(STEPS);
    localparam logic [STP_W-1:0] LAST_STEP = STP_W'(STEPS - 1);

    logic             busy_q;
    logic             done_q;
    logic [STP_W-1:0] step_q;
    logic [SH_W-1:0]  sh_q;
    logic [SET_W-1:0] rem_q;
    logic [SET_W-1:0] rem_d;

    // one restoring step per bit: r = (2r + b) mod SETS, r stays below SETS
    always_comb begin
      logic [SET_W:0] t;
      rem_d = rem_q;
      for (int i = 0; i < DIG; i++) begin
        t = {rem_d, sh_q[SH_W-1-i]};
        if (t >= (SET_W + 1)'(SETS)) begin
          t = t - (SET_W + 1)'(SETS);
        end
        rem_d = t[SET_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        step_q <= '0;
      end else begin
        done_q <= busy_q && (step_q == LAST_STEP);
        if (start_i) begin
          busy_q <= 1'b1;
          step_q <= '0;
        end else if (busy_q) begin
          step_q <= step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            busy_q <= 1'b0;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= SH_W'(value_i);
        rem_q <= '0;
      end else if (busy_q) begin
        sh_q  <= sh_q << DIG;
        rem_q <= rem_d;
      end
    end

    assign done_o = done_q;
    assign set_o  = rem_q;
  end

endmodule

@@ rtl/core/btbr_entry_mem.sv @@
// Single-port-write, registered-read entry memory of the target buffer.
`timescale 1ns / 1ps

module btbr_entry_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  btbr_pkg::btbr_entry_t wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output btbr_pkg::btbr_entry_t rdata_o
);
  import btbr_pkg::*;

  btbr_entry_t mem_q [DEPTH];
  btbr_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/btbr_way_scan.sv @@
// Shared way compare unit: tag match, first invalid way and oldest stamp, one way per step.
`timescale 1ns / 1ps

module btbr_way_scan #(
  parameter int unsigned WAY_W = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       step_i,
  input  logic [WAY_W-1:0]           way_i,
  input  btbr_pkg::btbr_entry_t      entry_i,
  input  logic [btbr_pkg::ADDR_W-1:0] addr_i,
  output logic                       match_o,
  output btbr_pkg::btbr_scan_t       result_o,
  output logic [WAY_W-1:0]           sel_way_o
);
  import btbr_pkg::*;

  logic              hit_q;
  logic              inv_q;
  logic [WAY_W-1:0]  hit_way_q;
  logic [WAY_W-1:0]  vic_q;
  logic [ADDR_W-1:0] tgt_q;
  logic [KIND_W-1:0] kind_q;
  logic [ADDR_W-1:0] min_q;
  logic              older;

  assign match_o = entry_i.valid && (entry_i.address == addr_i);
  // strict compare keeps the lowest way on equal stamps
  assign older   = (way_i == '0) || (min_q > entry_i.stamp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (clear_i) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (step_i) begin
      if (match_o) begin
        hit_q <= 1'b1;
      end
      if (!entry_i.valid) begin
        inv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !clear_i) begin
      if (match_o) begin
        hit_way_q <= way_i;
        tgt_q     <= entry_i.target;
        kind_q    <= entry_i.kind;
      end
      if (!inv_q) begin
        if (!entry_i.valid) begin
          vic_q <= way_i;
        end else if (older) begin
          vic_q <= way_i;
          min_q <= entry_i.stamp;
        end
      end
    end
  end

  assign result_o.hit    = hit_q;
  assign result_o.kind   = kind_q;
  assign result_o.target = tgt_q;
  assign sel_way_o       = hit_q ? hit_way_q : vic_q;

endmodule

@@ rtl/core/btb_branch_resolve_lru_unit.sv @@
// Top level: set-associative branch target buffer with LRU replacement, one branch per item.
`timescale 1ns / 1ps

// Resolves one branch per input beat against a SETS x WAYS target buffer held in a
// single memory, one entry per address. After reset a clearing pass writes each of
// the SETS*WAYS entries (2048 by default) invalid, with the input not ready. An item
// then reads the ways of its set in turn until a hit, or all WAYS on a miss: each
// way costs one memory read (S_READ) and one pass through the shared compare unit
// (S_CMP), and S_WB then writes back tag, target and stamp once the output register
// is free. When SETS is not a power of two the set index comes out of a remainder
// loop. The result beat sits in an output register, so the next item can be
// accepted while it waits. Penalties are to be written through the cfg port only
// while idle: the user is bound to that, as the block itself does not enforce it.
module btb_branch_resolve_lru_unit #(
  parameter int unsigned SETS = 512,
  parameter int unsigned WAYS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [btbr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [btbr_pkg::PEN_W-1:0]           cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // branch_address[63:0], branch_size[67:64], next_address[131:68],
  // predicted_taken[132], now[196:133], zero pad
  input  logic [btbr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // branch_kind[2:0]
  input  logic [btbr_pkg::KIND_W-1:0]          s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // btb_hit[0], resolved_taken[1], mispredicted[2], stall_cycles[13:3],
  // hit_total[45:14], miss_total[77:46], taken_total[109:78],
  // taken_wrong_total[141:110], not_taken_total[173:142],
  // not_taken_wrong_total[205:174], zero pad
  output logic [btbr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import btbr_pkg::*;

  localparam int unsigned ENTRIES = SETS * WAYS;
  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);
  localparam int unsigned PAD_W = OUT_TDATA_W - 3 - STALL_W - 6 * CNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INDEX,
    S_READ,
    S_CMP,
    S_WB
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [WAY_W-1:0]  way_q, way_d;

  logic [PEN_W-1:0]  miss_pen_q;
  logic [PEN_W-1:0]  mispred_pen_q;

  logic [CNT_W-1:0]  hit_cnt_q, miss_cnt_q, tk_cnt_q, tk_wr_cnt_q, nt_cnt_q, nt_wr_cnt_q;
  logic [CNT_W-1:0]  hit_cnt_d, miss_cnt_d, tk_cnt_d, tk_wr_cnt_d, nt_cnt_d, nt_wr_cnt_d;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic [OUT_TDATA_W-1:0] out_data_d;

  // captured branch
  logic [ADDR_W-1:0] in_addr_q;
  logic [ADDR_W-1:0] in_next_q;
  logic [ADDR_W-1:0] in_now_q;
  logic [ADDR_W-1:0] fall_q;
  logic [KIND_W-1:0] in_kind_q;
  logic              in_pred_q;

  logic              accept;
  logic              idx_done;
  logic [SET_W-1:0]  idx_set;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;
  btbr_entry_t       mem_wdata;
  btbr_entry_t       mem_rdata;
  btbr_entry_t       wb_entry;
  logic              scan_clear;
  logic              scan_step;
  logic              scan_match;
  btbr_scan_t        scan_res;
  logic [WAY_W-1:0]  sel_way;
  logic              out_free;
  logic              out_load;

  logic [ADDR_W-1:0]  tgt_sel;
  logic [KIND_W-1:0]  kind_sel;
  logic               taken;
  logic               wrong;
  logic               miss;
  logic [STALL_W-1:0] stall;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  btbr_set_index #(
    .SETS  (SETS),
    .SET_W (SET_W)
  ) u_set_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .value_i (s_axis_tdata[ADDR_W-1:SET_SHIFT]),
    .done_o  (idx_done),
    .set_o   (idx_set)
  );

  btbr_entry_mem #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  btbr_way_scan #(
    .WAY_W (WAY_W)
  ) u_way_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (scan_clear),
    .step_i    (scan_step),
    .way_i     (way_q),
    .entry_i   (mem_rdata),
    .addr_i    (in_addr_q),
    .match_o   (scan_match),
    .result_o  (scan_res),
    .sel_way_o (sel_way)
  );

  // resolve: a hit uses what was stored at install time
  assign miss     = !scan_res.hit;
  assign tgt_sel  = scan_res.hit ? scan_res.target : fall_q;
  assign kind_sel = scan_res.hit ? scan_res.kind : in_kind_q;
  assign taken    = (in_next_q != tgt_sel) && (kind_sel == KIND_COND);
  assign wrong    = (in_pred_q != taken);
  assign stall    = (miss ? STALL_W'(miss_pen_q) : '0) + (wrong ? STALL_W'(mispred_pen_q) : '0);

  assign wb_entry.valid   = 1'b1;
  assign wb_entry.kind    = kind_sel;
  assign wb_entry.address = in_addr_q;
  assign wb_entry.target  = tgt_sel;
  assign wb_entry.stamp   = in_now_q;

  assign hit_cnt_d   = hit_cnt_q + CNT_W'(scan_res.hit);
  assign miss_cnt_d  = miss_cnt_q + CNT_W'(miss);
  assign tk_cnt_d    = tk_cnt_q + CNT_W'(taken);
  assign tk_wr_cnt_d = tk_wr_cnt_q + CNT_W'(taken && wrong);
  assign nt_cnt_d    = nt_cnt_q + CNT_W'(!taken);
  assign nt_wr_cnt_d = nt_wr_cnt_q + CNT_W'(!taken && wrong);

  assign out_data_d = {{PAD_W{1'b0}}, nt_wr_cnt_d, nt_cnt_d, tk_wr_cnt_d, tk_cnt_d,
                       miss_cnt_d, hit_cnt_d, stall, wrong, taken, scan_res.hit};

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    base_d     = base_q;
    way_d      = way_q;
    mem_we     = 1'b0;
    mem_waddr  = clr_q;
    mem_wdata  = '0;
    mem_raddr  = base_q + IDX_W'(way_q);
    scan_clear = 1'b0;
    scan_step  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_INDEX;
        end
      end
      S_INDEX: begin
        if (idx_done) begin
          base_d     = IDX_W'(IDX_W'(idx_set) * IDX_W'(WAYS));
          way_d      = '0;
          scan_clear = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        scan_step = 1'b1;
        if (scan_match || (way_q == LAST_WAY)) begin
          state_d = S_WB;
        end else begin
          way_d   = way_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_WB: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = base_q + IDX_W'(sel_way);
          mem_wdata = wb_entry;
          out_load  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      base_q        <= '0;
      way_q         <= '0;
      miss_pen_q    <= '0;
      mispred_pen_q <= '0;
      hit_cnt_q     <= '0;
      miss_cnt_q    <= '0;
      tk_cnt_q      <= '0;
      tk_wr_cnt_q   <= '0;
      nt_cnt_q      <= '0;
      nt_wr_cnt_q   <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      base_q  <= base_d;
      way_q   <= way_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_MISS_PEN:    miss_pen_q    <= cfg_data_i;
          REG_MISPRED_PEN: mispred_pen_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        tk_cnt_q    <= tk_cnt_d;
        tk_wr_cnt_q <= tk_wr_cnt_d;
        nt_cnt_q    <= nt_cnt_d;
        nt_wr_cnt_q <= nt_wr_cnt_d;
        out_data_q  <= out_data_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_addr_q <= s_axis_tdata[63:0];
      in_next_q <= s_axis_tdata[131:68];
      in_pred_q <= s_axis_tdata[132];
      in_now_q  <= s_axis_tdata[196:133];
      in_kind_q <= s_axis_tuser;
      fall_q    <= s_axis_tdata[63:0] + ADDR_W'(s_axis_tdata[67:64]);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // every resolved branch is counted as exactly one of hit or miss
  a_hit_miss_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (CNT_W'(hit_cnt_q + miss_cnt_q) ==
                  CNT_W'($past(hit_cnt_q) + $past(miss_cnt_q) + CNT_W'(1))))
    else $error("hit and miss totals out of step");

  // writeback always installs a valid entry tagged with the branch address
  a_wb_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q == S_WB)) |-> (mem_wdata.valid && (mem_wdata.address == in_addr_q)))
    else $error("writeback entry malformed");

  // the mispredict flag of each beat agrees with the taken flag and the guess
  a_mispred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_data_q[2] == ($past(in_pred_q) != out_data_q[1])))
    else $error("mispredict flag inconsistent");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the branch target buffer resolve unit.
`timescale 1ns / 1ps

typedef struct packed {
  logic [btbr_pkg::ADDR_W-1:0] address;
  logic [btbr_pkg::SIZE_W-1:0] size;
  logic [btbr_pkg::KIND_W-1:0] kind;
  logic [btbr_pkg::ADDR_W-1:0] next_address;
  logic                        predicted_taken;
  logic [btbr_pkg::ADDR_W-1:0] now;
} branch_t;

// declared top field first so the struct lines up with m_axis_tdata bit 0 upward
typedef struct packed {
  logic [btbr_pkg::CNT_W-1:0]   not_taken_wrong_total;
  logic [btbr_pkg::CNT_W-1:0]   not_taken_total;
  logic [btbr_pkg::CNT_W-1:0]   taken_wrong_total;
  logic [btbr_pkg::CNT_W-1:0]   taken_total;
  logic [btbr_pkg::CNT_W-1:0]   miss_total;
  logic [btbr_pkg::CNT_W-1:0]   hit_total;
  logic [btbr_pkg::STALL_W-1:0] stall;
  logic                         wrong;
  logic                         taken;
  logic                         hit;
} outcome_t;

module testbench;
  import btbr_pkg::*;

  localparam int unsigned SETS             = 512;
  localparam int unsigned WAYS             = 4;
  localparam int unsigned RANDOM_PER_PHASE = 500;
  localparam int unsigned DRAIN_CYCLES     = 24;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned POOL_SIZE        = 32;
  localparam int unsigned HOT_SETS         = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [KIND_W-1:0]    KIND_LAST   = 3'd7;

  typedef enum {READY_ALWAYS, READY_COIN, READY_RUNS} ready_mode_e;

  class btb_resolve_tracker;
    localparam int unsigned ENTRIES = SETS * WAYS;
    localparam int unsigned MAX_PRINTED = 40;

    logic [btbr_pkg::ADDR_W-1:0] addr_mem   [ENTRIES];
    logic [btbr_pkg::ADDR_W-1:0] target_mem [ENTRIES];
    logic [btbr_pkg::ADDR_W-1:0] stamp_mem  [ENTRIES];
    logic [btbr_pkg::KIND_W-1:0] kind_mem   [ENTRIES];
    bit                          valid_mem  [ENTRIES];

    logic [btbr_pkg::CNT_W-1:0] hit_n, miss_n, taken_n, taken_wrong_n, nt_n, nt_wrong_n;
    logic [btbr_pkg::PEN_W-1:0] miss_pen, mispred_pen;

    outcome_t    outcome_q[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        addr_mem[i]   = '0;
        target_mem[i] = '0;
        stamp_mem[i]  = '0;
        kind_mem[i]   = '0;
        valid_mem[i]  = 1'b0;
      end
      hit_n = '0; miss_n = '0; taken_n = '0; taken_wrong_n = '0; nt_n = '0; nt_wrong_n = '0;
      miss_pen = '0;
      mispred_pen = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [btbr_pkg::CFG_IDX_W-1:0] idx,
                          logic [btbr_pkg::PEN_W-1:0] data);
      if (idx == btbr_pkg::REG_MISS_PEN) miss_pen = data;
      else if (idx == btbr_pkg::REG_MISPRED_PEN) mispred_pen = data;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    // look up, install or refresh, then resolve direction and bump the totals
    function void note_branch(branch_t b);
      outcome_t    o;
      int unsigned base;
      int unsigned way;
      int unsigned e;
      o = '0;
      base = int'((b.address >> btbr_pkg::SET_SHIFT) % SETS) * WAYS;
      way = 0;
      for (int w = 0; w < WAYS; w++) begin
        if (!o.hit && valid_mem[base+w] && addr_mem[base+w] == b.address) begin
          o.hit = 1'b1;
          way = w;
        end
      end
      if (o.hit) begin
        stamp_mem[base+way] = b.now;
        hit_n++;
      end else begin
        miss_n++;
        way = WAYS;
        for (int w = WAYS - 1; w >= 0; w--) if (!valid_mem[base+w]) way = w;
        if (way == WAYS) begin
          // oldest stamp, strict compare keeps the lowest way on a tie
          way = 0;
          for (int w = 1; w < WAYS; w++)
            if (stamp_mem[base+w] < stamp_mem[base+way]) way = w;
        end
        e = base + way;
        addr_mem[e]   = b.address;
        stamp_mem[e]  = b.now;
        target_mem[e] = b.address + 64'(b.size);
        valid_mem[e]  = 1'b1;
        kind_mem[e]   = b.kind;
      end
      e = base + way;
      o.taken = (b.next_address != target_mem[e]) && (kind_mem[e] == btbr_pkg::KIND_COND);
      o.wrong = b.predicted_taken != o.taken;
      if (o.taken) begin
        taken_n++;
        if (o.wrong) taken_wrong_n++;
      end else begin
        nt_n++;
        if (o.wrong) nt_wrong_n++;
      end
      o.stall = (o.hit ? 11'd0 : 11'(miss_pen)) + (o.wrong ? 11'(mispred_pen) : 11'd0);
      o.hit_total             = hit_n;
      o.miss_total            = miss_n;
      o.taken_total           = taken_n;
      o.taken_wrong_total     = taken_wrong_n;
      o.not_taken_total       = nt_n;
      o.not_taken_wrong_total = nt_wrong_n;
      outcome_q.push_back(o);
    endfunction

    task report(string msg);
      errors++;
      // keep the log short when everything goes wrong
      if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s: got %0h want %0h", checked, name, got, want));
    endtask

    task check_resolve(logic [btbr_pkg::OUT_TDATA_W-1:0] data);
      outcome_t got;
      outcome_t want;
      got = outcome_t'(data[$bits(outcome_t)-1:0]);
      if (outcome_q.size() == 0) begin
        report($sformatf("beat %0d arrived with no branch outstanding", checked));
      end else begin
        want = outcome_q.pop_front();
        check_field("btb_hit", got.hit, want.hit);
        check_field("resolved_taken", got.taken, want.taken);
        check_field("mispredicted", got.wrong, want.wrong);
        check_field("stall_cycles", got.stall, want.stall);
        check_field("hit_total", got.hit_total, want.hit_total);
        check_field("miss_total", got.miss_total, want.miss_total);
        check_field("taken_total", got.taken_total, want.taken_total);
        check_field("taken_wrong_total", got.taken_wrong_total, want.taken_wrong_total);
        check_field("not_taken_total", got.not_taken_total, want.not_taken_total);
        check_field("not_taken_wrong_total", got.not_taken_wrong_total,
                    want.not_taken_wrong_total);
      end
      checked++;
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [PEN_W-1:0]       cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [KIND_W-1:0]      s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  btb_resolve_tracker tracker = new();

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned settings_n  = 0;

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  logic [8:0]        hot_set   [HOT_SETS];
  logic [ADDR_W-1:0] stamp_clock = '0;

  btb_branch_resolve_lru_unit #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // result side: consume beats and stall, switching at random between always ready, coin-flip ready and ready runs
  initial begin : result_sink
    ready_mode_e mode;
    int unsigned mode_left;
    int unsigned run_left;
    logic        run_ready;
    mode = READY_ALWAYS;
    mode_left = 0;
    run_left = 0;
    run_ready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_resolve(m_axis_tdata);
      if (mode_left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (mode)
        READY_ALWAYS: m_axis_tready <= 1'b1;
        READY_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            run_ready = !run_ready;
            run_left = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 16);
          end else begin
            run_left--;
          end
          m_axis_tready <= run_ready;
        end
      endcase
    end
  end

  function automatic branch_t mk_branch(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s,
                                        logic [KIND_W-1:0] k, logic [ADDR_W-1:0] n,
                                        logic p, logic [ADDR_W-1:0] t);
    branch_t b;
    b.address = a;
    b.size = s;
    b.kind = k;
    b.next_address = n;
    b.predicted_taken = p;
    b.now = t;
    return b;
  endfunction

  function automatic logic [ADDR_W-1:0] fresh_hot_address();
    logic [ADDR_W-1:0] a;
    a = {$urandom, $urandom};
    a[10:2] = hot_set[$urandom_range(0, HOT_SETS - 1)];
    return a;
  endfunction

  // valid stays high on return so the next beat can follow without a bubble
  task automatic send_branch(branch_t b);
    s_axis_tdata  <= {3'b000, b.now, b.predicted_taken, b.next_address, b.size, b.address};
    s_axis_tuser  <= b.kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_branch(b);
    items_sent++;
  endtask

  // spare indexes go last, so a decode slip would corrupt the live penalties
  task automatic program_penalties(logic [PEN_W-1:0] miss_pen, logic [PEN_W-1:0] mispred_pen);
    logic [PEN_W-1:0] junk_a;
    logic [PEN_W-1:0] junk_b;
    junk_a = PEN_W'($urandom);
    junk_b = PEN_W'($urandom);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_MISS_PEN;
    cfg_data_i <= miss_pen;
    @(posedge clk_i);
    cfg_index_i <= REG_MISPRED_PEN;
    cfg_data_i <= mispred_pen;
    @(posedge clk_i);
    cfg_index_i <= REG_SPARE_A;
    cfg_data_i <= junk_a;
    @(posedge clk_i);
    cfg_index_i <= REG_SPARE_B;
    cfg_data_i <= junk_b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(REG_MISS_PEN, miss_pen);
    tracker.set_reg(REG_MISPRED_PEN, mispred_pen);
    tracker.set_reg(REG_SPARE_A, junk_a);
    tracker.set_reg(REG_SPARE_B, junk_b);
    settings_n++;
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [PEN_W-1:0]  miss_set    [4];
    logic [PEN_W-1:0]  mispred_set [4];
    logic [ADDR_W-1:0] tie_base;
    logic [ADDR_W-1:0] ones;
    int unsigned       burst_left;
    int unsigned       gap;
    branch_t           b;
    int unsigned       pick;
    int unsigned       roll;

    for (int i = 0; i < HOT_SETS; i++) hot_set[i] = 9'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = fresh_hot_address();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass holds tready low
    do @(posedge clk_i); while (!s_axis_tready);

    // directed: hit/miss with every direction outcome, wraps, stale entry, LRU ties
    program_penalties('1, '1);
    ones = '1;
    tie_base = 64'd5 << SET_SHIFT;
    send_branch(mk_branch(64'h0, 4'd4, KIND_COND, 64'h4, 1'b0, 64'h0));
    send_branch(mk_branch(64'h0, 4'd4, KIND_COND, 64'h100, 1'b1, 64'h1));
    send_branch(mk_branch(64'h0, 4'd4, KIND_COND, 64'h100, 1'b0, 64'h2));
    send_branch(mk_branch(64'h0, 4'd4, KIND_COND, 64'h4, 1'b1, 64'h3));
    // fall-through wraps past the top of the address space
    send_branch(mk_branch(ones, 4'd15, KIND_LAST, 64'h0, 1'b1, ones));
    // stale kind: stored unconditional kind wins over the current one
    send_branch(mk_branch(ones, 4'd0, KIND_COND, 64'h5, 1'b0, ones));
    send_branch(mk_branch(64'h0123_4567_89ab_cdef, 4'd0, KIND_COND, 64'h0123_4567_89ab_cdef,
                          1'b0, 64'd10));
    send_branch(mk_branch(64'h0123_4567_89ab_cdef, 4'd0, KIND_COND, 64'h0123_4567_89ab_cdf0,
                          1'b1, 64'd11));
    // fill one set with equal stamps, then overflow it four times
    for (int k = 1; k <= 5; k++)
      send_branch(mk_branch(tie_base | (64'(k) << 11), 4'd2, KIND_COND, 64'h0, 1'b1, 64'd100));
    send_branch(mk_branch(tie_base | (64'd1 << 11), 4'd2, KIND_COND, 64'h0, 1'b0, 64'd101));
    send_branch(mk_branch(tie_base | (64'd3 << 11), 4'd2, KIND_COND, 64'h0, 1'b0, 64'd200));
    send_branch(mk_branch(tie_base | (64'd6 << 11), 4'd9, 3'd3, 64'h0, 1'b1, 64'd201));
    send_branch(mk_branch(tie_base | (64'd2 << 11), 4'd2, KIND_COND, 64'h0, 1'b0, 64'd202));
    // same set and upper bits, different low bits: a separate entry
    send_branch(mk_branch(tie_base | (64'd3 << 11) | 64'd1, 4'd1, 3'd5, ones, 1'b0, 64'd203));
    send_branch(mk_branch(64'h8000_0000_0000_0000, 4'd8, 3'd6, 64'h7fff_ffff_ffff_ffff, 1'b1,
                          64'h8000_0000_0000_0000));
    s_axis_tvalid <= 1'b0;
    wait_drained();

    miss_set[0] = '0;               mispred_set[0] = '0;
    miss_set[1] = PEN_W'($urandom); mispred_set[1] = PEN_W'($urandom);
    miss_set[2] = '1;               mispred_set[2] = '0;
    miss_set[3] = '0;               mispred_set[3] = '1;
    stamp_clock = 64'd1000;

    for (int p = 0; p < 4; p++) begin
      program_penalties(miss_set[p], mispred_set[p]);
      burst_left = 0;
      repeat (RANDOM_PER_PHASE) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
          gap = $urandom_range(0, 10);
          if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        burst_left--;

        // mostly a small pool of addresses crowding a few sets, so hits and evictions mix
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, POOL_SIZE - 1);
        if (roll < 75) begin
          b.address = addr_pool[pick];
        end else if (roll < 88) begin
          addr_pool[pick] = fresh_hot_address();
          b.address = addr_pool[pick];
        end else begin
          b.address = {$urandom, $urandom};
        end
        b.size = SIZE_W'($urandom_range(0, 15));
        b.kind = ($urandom_range(0, 1) == 0) ? KIND_COND : KIND_W'($urandom_range(0, 7));
        roll = $urandom_range(0, 9);
        if (roll < 4) b.next_address = b.address + 64'(b.size);
        else if (roll < 6) b.next_address = b.address + 64'($urandom_range(0, 15));
        else b.next_address = {$urandom, $urandom};
        b.predicted_taken = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 85) stamp_clock = stamp_clock + 64'($urandom_range(0, 3));
        else if (roll < 95) stamp_clock = {$urandom, $urandom};
        b.now = stamp_clock;
        send_branch(b);
      end
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    $display("covered %0d branches under %0d penalty settings: %0d hits, %0d misses",
             items_sent, settings_n, tracker.hit_n, tracker.miss_n);
    $display("resolved %0d taken, %0d not taken; %0d mismatches",
             tracker.taken_n, tracker.nt_n, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
